@@ hdl/ale_pkg.sv @@
package ale_pkg;

    // Default sizes handed down to the top level.
    localparam int CAPACITY_DEF  = 64;
    localparam int WORD_BITS_DEF = 32;

    // Fixed field widths of the stream words.
    localparam int CMD_W   = 3;
    localparam int POS_W   = 7;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 3;
    localparam int LEN_W   = 7;
    localparam int IN_DW   = 48;
    localparam int OUT_DW  = 16;

    // Command codes carried in the input word.
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK    = 3'd0,
        CMD_PUSH_FRONT   = 3'd1,
        CMD_INSERT       = 3'd2,
        CMD_POP_BACK     = 3'd3,
        CMD_POP_FRONT    = 3'd4,
        CMD_ERASE        = 3'd5,
        CMD_REMOVE_FIRST = 3'd6,
        CMD_REMOVE_ALL   = 3'd7
    } t_cmd;

    // Status codes carried in the output word.
    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_BAD_POS   = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    // Kind of entry-moving loop run by the datapath.
    typedef enum logic [1:0] {
        MODE_UP        = 2'd0,
        MODE_DROP      = 2'd1,
        MODE_REM_FIRST = 2'd2,
        MODE_REM_ALL   = 2'd3
    } t_mode;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;
        logic    start;
        t_mode   mode;
        logic    push_tail;
        logic    pop_tail;
        logic    step;
        logic    loop_end;
        logic    res_load;
        t_status res_status;
        logic    out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_cmd cmd;
        logic empty;
        logic full;
        logic pos_above;
        logic pos_at_or_above;
        logic loop_done;
    } t_dp_stat;

endpackage

@@ hdl/ale_datapath.sv @@
module ale_datapath
    import ale_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [POS_W-1:0]    i_position,
    input  logic [VAL_W-1:0]    i_value,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    output logic [STAT_W-1:0]   o_status,
    output logic [LEN_W-1:0]    o_length_after
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    // List store: one write port, one registered read port.
    logic [WORD_BITS-1:0] r_mem [CAPACITY];
    logic [WORD_BITS-1:0] r_rdata;

    // Captured command.
    t_cmd                 r_cmd,    n_cmd;
    logic [POS_W-1:0]     r_pos,    n_pos;
    logic [WORD_BITS-1:0] r_word,   n_word;

    // List length and loop state.
    logic [CW-1:0]        r_count,  n_count;
    logic [CW-1:0]        r_rd_idx, n_rd_idx;
    logic [CW-1:0]        r_wr_idx, n_wr_idx;
    logic [CW-1:0]        r_left,   n_left;
    logic                 r_pend,   n_pend;
    logic                 r_found,  n_found;
    t_mode                r_mode,   n_mode;

    // Result registers.
    t_status              r_status, n_status;
    logic [STAT_W-1:0]    r_out_status, n_out_status;
    logic [LEN_W-1:0]     r_out_len,    n_out_len;

    logic [CW-1:0]        w_pos_c;
    logic                 w_eq;
    logic                 w_keep;
    logic                 w_we;
    logic [AW-1:0]        w_wa;
    logic [WORD_BITS-1:0] w_wd;
    t_cmd                 w_in_cmd;

    assign w_in_cmd = t_cmd'(i_command);
    assign w_pos_c  = CW'(r_pos);
    assign w_eq     = (r_rdata == r_word);

    // Decide whether the word just read survives a compaction step.
    always_comb begin
        case (r_mode)
            MODE_REM_FIRST: w_keep = !(w_eq && !r_found);
            MODE_REM_ALL:   w_keep = !w_eq;
            default:        w_keep = 1'b1;
        endcase
    end

    // Write port selection.
    always_comb begin
        w_we = 1'b0;
        w_wa = r_count[AW-1:0];
        w_wd = r_word;
        if (i_cmd.loop_end && (r_mode == MODE_UP)) begin
            w_we = 1'b1;
            w_wa = w_pos_c[AW-1:0];
        end else if (i_cmd.step && r_pend && ((r_mode == MODE_UP) || w_keep)) begin
            w_we = 1'b1;
            w_wa = r_wr_idx[AW-1:0];
            w_wd = r_rdata;
        end else if (i_cmd.push_tail) begin
            w_we = 1'b1;
        end
    end

    // Memory array.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rdata <= r_mem[r_rd_idx[AW-1:0]];
    end

    // Next-value logic for the loop and the length.
    always_comb begin
        n_cmd        = r_cmd;
        n_pos        = r_pos;
        n_word       = r_word;
        n_count      = r_count;
        n_rd_idx     = r_rd_idx;
        n_wr_idx     = r_wr_idx;
        n_left       = r_left;
        n_pend       = r_pend;
        n_found      = r_found;
        n_mode       = r_mode;
        n_status     = r_status;
        n_out_status = r_out_status;
        n_out_len    = r_out_len;

        if (i_cmd.capture) begin
            n_cmd  = w_in_cmd;
            n_word = WORD_BITS'(i_value);
            if ((w_in_cmd == CMD_PUSH_FRONT) || (w_in_cmd == CMD_POP_FRONT)) begin
                n_pos = '0;
            end else begin
                n_pos = i_position;
            end
        end

        // Set up the read and write pointers for a loop.
        if (i_cmd.start) begin
            n_mode  = i_cmd.mode;
            n_found = 1'b0;
            n_pend  = 1'b0;
            case (i_cmd.mode)
                MODE_UP: begin
                    n_rd_idx = r_count - CW'(1);
                    n_left   = r_count - w_pos_c;
                    n_wr_idx = r_count;
                end
                MODE_DROP: begin
                    n_rd_idx = w_pos_c + CW'(1);
                    n_left   = r_count - w_pos_c - CW'(1);
                    n_wr_idx = w_pos_c;
                end
                default: begin
                    n_rd_idx = '0;
                    n_left   = r_count;
                    n_wr_idx = '0;
                end
            endcase
        end

        // One loop step: issue the next read and retire the previous one.
        if (i_cmd.step) begin
            if (r_left != '0) begin
                n_pend = 1'b1;
                n_left = r_left - CW'(1);
                if (r_mode == MODE_UP) begin
                    n_rd_idx = r_rd_idx - CW'(1);
                end else begin
                    n_rd_idx = r_rd_idx + CW'(1);
                end
            end else begin
                n_pend = 1'b0;
            end
            if (r_pend) begin
                if (r_mode == MODE_UP) begin
                    n_wr_idx = r_wr_idx - CW'(1);
                end else if (w_keep) begin
                    n_wr_idx = r_wr_idx + CW'(1);
                end
                if (r_mode == MODE_REM_FIRST) begin
                    n_found = r_found | w_eq;
                end
            end
        end

        if (i_cmd.push_tail) begin
            n_count = r_count + CW'(1);
        end
        if (i_cmd.pop_tail) begin
            n_count = r_count - CW'(1);
        end

        // Close a loop: place the new word or take the compacted length.
        if (i_cmd.loop_end) begin
            n_status = ST_OK;
            if (r_mode == MODE_UP) begin
                n_count = r_count + CW'(1);
            end else begin
                n_count = r_wr_idx;
                if ((r_mode == MODE_REM_FIRST) && !r_found) begin
                    n_status = ST_NOT_FOUND;
                end
            end
        end

        if (i_cmd.res_load) begin
            n_status = i_cmd.res_status;
        end

        if (i_cmd.out_load) begin
            n_out_status = r_status;
            n_out_len    = LEN_W'(r_count);
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_left  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_left  <= n_left;
            r_pend  <= n_pend;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_pos        <= n_pos;
        r_word       <= n_word;
        r_rd_idx     <= n_rd_idx;
        r_wr_idx     <= n_wr_idx;
        r_found      <= n_found;
        r_mode       <= n_mode;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_len    <= n_out_len;
    end

    // Status toward the controller.
    always_comb begin
        o_stat.cmd             = r_cmd;
        o_stat.empty           = (r_count == '0);
        o_stat.full            = (r_count == CW'(CAPACITY));
        o_stat.pos_above       = (PW'(r_pos) > PW'(r_count));
        o_stat.pos_at_or_above = (PW'(r_pos) >= PW'(r_count));
        o_stat.loop_done       = (r_left == '0) && !r_pend;
    end

    assign o_status       = r_out_status;
    assign o_length_after = r_out_len;

endmodule

@@ hdl/ale_ctrl.sv @@
module ale_ctrl
    import ale_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECODE = 4'b0010,
        S_LOOP   = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // Sequencing of one command.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                case (i_stat.cmd)
                    CMD_PUSH_BACK: begin
                        o_cmd.res_load = 1'b1;
                        if (i_stat.full) begin
                            o_cmd.res_status = ST_FULL;
                        end else begin
                            o_cmd.res_status = ST_OK;
                            o_cmd.push_tail  = 1'b1;
                        end
                    end
                    CMD_PUSH_FRONT, CMD_INSERT: begin
                        if ((i_stat.cmd == CMD_INSERT) && i_stat.pos_above) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_BAD_POS;
                        end else if (i_stat.full) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_FULL;
                        end else begin
                            o_cmd.start = 1'b1;
                            o_cmd.mode  = MODE_UP;
                            n_state     = S_LOOP;
                        end
                    end
                    CMD_POP_BACK: begin
                        o_cmd.res_load = 1'b1;
                        if (i_stat.empty) begin
                            o_cmd.res_status = ST_EMPTY;
                        end else begin
                            o_cmd.res_status = ST_OK;
                            o_cmd.pop_tail   = 1'b1;
                        end
                    end
                    CMD_POP_FRONT, CMD_ERASE: begin
                        if (i_stat.empty) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_EMPTY;
                        end else if ((i_stat.cmd == CMD_ERASE) && i_stat.pos_at_or_above) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_BAD_POS;
                        end else begin
                            o_cmd.start = 1'b1;
                            o_cmd.mode  = MODE_DROP;
                            n_state     = S_LOOP;
                        end
                    end
                    CMD_REMOVE_FIRST: begin
                        o_cmd.start = 1'b1;
                        o_cmd.mode  = MODE_REM_FIRST;
                        n_state     = S_LOOP;
                    end
                    default: begin
                        o_cmd.start = 1'b1;
                        o_cmd.mode  = MODE_REM_ALL;
                        n_state     = S_LOOP;
                    end
                endcase
            end
            S_LOOP: begin
                o_cmd.step = 1'b1;
                if (i_stat.loop_done) begin
                    o_cmd.loop_end = 1'b1;
                    n_state        = S_DONE;
                end
            end
            S_DONE: begin
                // Hand the result to the output register once it is free.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output word valid flag.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ hdl/array_list_engine.sv @@
// Channel  | Direction | Word contents (lowest bit first)
// ---------+-----------+-------------------------------------------------
// s_axis   | in        | command[2:0], position[9:3], value[41:10], zeros
// m_axis   | out       | status[2:0], length_after[9:3], zeros
//
// A command whose result is settled at decode passes through the DECODE and DONE
// states after it is accepted. A shift or compaction loop adds the LOOP state, in
// which it reads N entries (length - position for an insert, the entries above the
// position for an erase, the whole length for removals) one at a time, as the list
// store has one registered read port and one write port. The next word is taken the
// cycle after the result is loaded, so a new command is taken only once the last
// one's result is loaded. Reset is synchronous and empties the list. A result held
// by a stalled m_axis does not stop the next command from being taken, but that
// command waits for the output register to free up.
module array_list_engine
    import ale_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [IN_DW-1:0]  i_s_axis_tdata,   // command, position, value
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [OUT_DW-1:0] o_m_axis_tdata    // status, length_after
);

    t_dp_cmd           w_cmd;
    t_dp_stat          w_stat;
    logic [STAT_W-1:0] w_status;
    logic [LEN_W-1:0]  w_length_after;

    // Command sequencer.
    ale_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // List store, pointers and result registers.
    ale_datapath #(
        .CAPACITY  (CAPACITY),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_command      (i_s_axis_tdata[CMD_W-1:0]),
        .i_position     (i_s_axis_tdata[CMD_W+POS_W-1:CMD_W]),
        .i_value        (i_s_axis_tdata[CMD_W+POS_W+VAL_W-1:CMD_W+POS_W]),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_status       (w_status),
        .o_length_after (w_length_after)
    );

    // Pack the result word.
    assign o_m_axis_tdata = {{(OUT_DW - STAT_W - LEN_W){1'b0}}, w_length_after, w_status};

endmodule
